>>> src/pvh_pkg.sv
// shared types and constants for the polyval hash block
package pvh_pkg;

   localparam int unsigned WORD_W   = 64;
   localparam int unsigned FIELD_W  = 128;
   localparam int unsigned DIGIT_W  = 16;
   localparam int unsigned DIGITS   = FIELD_W / DIGIT_W;
   localparam int unsigned CNT_W    = $clog2(DIGITS);
   localparam int unsigned WIDE_W   = FIELD_W + DIGIT_W;

   // reduction taps of x^128 + x^127 + x^126 + x^121 + 1 above bit 0
   localparam int unsigned TAP_A = 121;
   localparam int unsigned TAP_B = 126;
   localparam int unsigned TAP_C = 127;
   localparam int unsigned TAP_D = 128;

   localparam logic CSR_KEY_LOW  = 1'b0;
   localparam logic CSR_KEY_HIGH = 1'b1;

   typedef struct packed {
      logic [WORD_W-1:0] block_low;
      logic [WORD_W-1:0] block_high;
      logic              last_block;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] digest_low;
      logic [WORD_W-1:0] digest_high;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } state_type;

endpackage

>>> src/polyval_hash.sv
// polyval hash top level: key registers, accumulator and digit sequencer
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    req_data  (block halves, last flag)
//   rsp      out        rsp_valid/ready    rsp_data  (digest halves)
//   csr      in         csr_write          csr_index, csr_wdata (key halves)
//
// each block is worked through one 16-bit digit at a time in the multiply-reduce
// unit once it is accepted; req_ready is high only while idle.
// reset is synchronous and clears the key, accumulator and control state.
// a last block whose digest finds the output register still full holds its
// final step until the output beat is taken.
module polyval_hash
   import pvh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [WORD_W-1:0]   csr_wdata
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [FIELD_W-1:0] key_ff, key_in;
   logic [FIELD_W-1:0] acc_ff, acc_in;
   logic [FIELD_W-1:0] opa_ff, opa_in;
   logic [FIELD_W-1:0] prod_ff, prod_in;
   logic               last_ff, last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [FIELD_W-1:0] step_out;
   logic               final_step;
   logic               advance;
   logic               req_beat;
   logic               rsp_beat;

   pvh_step u_step (
      .prod      (prod_ff),
      .digit     (opa_ff[DIGIT_W-1:0]),
      .key       (key_ff),
      .prod_next (step_out)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_beat   = req_valid && req_ready;
   assign rsp_beat   = rsp_valid_ff && rsp_ready;
   assign final_step = (cnt_ff == CNT_W'(DIGITS - 1));
   assign advance    = (state_ff == ST_BUSY)
                     && !(final_step && last_ff && rsp_valid_ff && !rsp_ready);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      key_in       = key_ff;
      acc_in       = acc_ff;
      opa_in       = opa_ff;
      prod_in      = prod_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_beat;
      rsp_data_in  = rsp_data_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_KEY_LOW:  key_in[WORD_W-1:0]       = csr_wdata;
            CSR_KEY_HIGH: key_in[FIELD_W-1:WORD_W] = csr_wdata;
            default:      key_in                   = key_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               opa_in   = acc_ff ^ {req_data.block_high, req_data.block_low};
               prod_in  = '0;
               last_in  = req_data.last_block;
               cnt_in   = '0;
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (advance) begin
               prod_in = step_out;
               opa_in  = opa_ff >> DIGIT_W;
               cnt_in  = cnt_ff + CNT_W'(1);
               if (final_step) begin
                  state_in = ST_IDLE;
                  cnt_in   = '0;
                  if (last_ff) begin
                     acc_in       = '0;
                     rsp_valid_in = 1'b1;
                     rsp_data_in.digest_low  = step_out[WORD_W-1:0];
                     rsp_data_in.digest_high = step_out[FIELD_W-1:WORD_W];
                  end else begin
                     acc_in = step_out;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         key_ff       <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         key_ff       <= key_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opa_ff      <= opa_in;
      prod_ff     <= prod_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // accepted beat starts the sequencer
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == ST_BUSY) && (cnt_ff == '0))
      else $error("accepted beat did not start the digit sequence");

   // a new digest beat only comes from a finishing last block
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_BUSY) && $past(last_ff))
      else $error("digest beat without a finished last block");

   // the digit counter rests at zero while idle
   a_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (cnt_ff == '0))
      else $error("digit counter not cleared while idle");

   // a pending digest is never overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending digest lost or changed");

endmodule

>>> src/pvh_step.sv
// one digit step of the interleaved carry-less montgomery multiply
module pvh_step
   import pvh_pkg::*;
(
   input  logic [FIELD_W-1:0] prod,
   input  logic [DIGIT_W-1:0] digit,
   input  logic [FIELD_W-1:0] key,
   output logic [FIELD_W-1:0] prod_next
);

   logic [WIDE_W-1:0]  part;
   logic [WIDE_W-1:0]  wide;
   logic [WIDE_W-1:0]  red;
   logic [DIGIT_W-1:0] m;

   always_comb begin
      part = '0;
      for (int i = 0; i < DIGIT_W; i++) begin
         if (digit[i]) begin
            part = part ^ ({{DIGIT_W{1'b0}}, key} << i);
         end
      end
      wide = part ^ {{DIGIT_W{1'b0}}, prod};
      m    = wide[DIGIT_W-1:0];
      red  = wide
           ^ {{FIELD_W{1'b0}}, m}
           ^ ({{FIELD_W{1'b0}}, m} << TAP_A)
           ^ ({{FIELD_W{1'b0}}, m} << TAP_B)
           ^ ({{FIELD_W{1'b0}}, m} << TAP_C)
           ^ ({{FIELD_W{1'b0}}, m} << TAP_D);
      prod_next = red[WIDE_W-1:DIGIT_W];
   end

endmodule
